/* src/gec_pkg.sv */
// Shared types, bus offsets and the brightness decode table for the GPIO edge
// interrupt controller. Used by every module under src; depends on nothing.
package gec_pkg;

    localparam int PIN_COUNT_DEF = 32;
    localparam int WORD_W        = 32;
    localparam int HALF_W        = 16;
    localparam int OFS_W         = 12;
    localparam int PIN_W         = 5;
    localparam int SEL_W         = 6;
    localparam int LEVEL_W       = 3;

    // Command queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [OFS_W-1:0] OFS_OUT_LO  = 12'h00C;
    localparam logic [OFS_W-1:0] OFS_IN_LO   = 12'h010;
    localparam logic [OFS_W-1:0] OFS_FALL_LO = 12'h014;
    localparam logic [OFS_W-1:0] OFS_RISE_LO = 12'h018;
    localparam logic [OFS_W-1:0] OFS_STAT_LO = 12'h020;
    localparam logic [OFS_W-1:0] OFS_OE_HI   = 12'h508;
    localparam logic [OFS_W-1:0] OFS_OUT_HI  = 12'h50C;
    localparam logic [OFS_W-1:0] OFS_IN_HI   = 12'h510;
    localparam logic [OFS_W-1:0] OFS_FALL_HI = 12'h514;
    localparam logic [OFS_W-1:0] OFS_RISE_HI = 12'h518;
    localparam logic [OFS_W-1:0] OFS_STAT_HI = 12'h520;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_PIN   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        K_NOP,
        K_READ,
        K_WRITE,
        K_PIN
    } t_kind;

    typedef enum logic [2:0] {
        REG_NONE,
        REG_OE,
        REG_OUT,
        REG_IN,
        REG_FALL,
        REG_RISE,
        REG_STAT
    } t_reg_sel;

    typedef struct packed {
        t_kind              kind;
        t_reg_sel           sel;
        logic               hi;
        logic [HALF_W-1:0]  data;
        logic [PIN_W-1:0]   pin;
        logic               level;
    } t_cmd;

    function automatic logic [LEVEL_W-1:0] decode_brightness(input logic [SEL_W-1:0] sel);
        logic [LEVEL_W-1:0] lvl;
        unique case (sel)
            6'h07:   lvl = 3'd0;
            6'h10:   lvl = 3'd1;
            6'h11:   lvl = 3'd2;
            6'h20:   lvl = 3'd3;
            6'h0E:   lvl = 3'd4;
            6'h15:   lvl = 3'd5;
            6'h23:   lvl = 3'd6;
            default: lvl = 3'd7;
        endcase
        return lvl;
    endfunction

endpackage

/* src/gec_front.sv */
// Front part: takes input beats, checks the pin range and decodes the bus
// offset into a command for the queue. Depends on gec_pkg.
module gec_front #(
    parameter int PIN_COUNT = gec_pkg::PIN_COUNT_DEF
) (
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_action,
    input  logic [gec_pkg::OFS_W-1:0]   i_bus_offset,
    input  logic [gec_pkg::HALF_W-1:0]  i_write_data,
    input  logic [gec_pkg::PIN_W-1:0]   i_pin_index,
    input  logic                        i_pin_level,
    input  logic                        i_q_full,
    output logic                        o_push,
    output gec_pkg::t_cmd               o_cmd
);

    localparam logic [gec_pkg::PIN_W:0] PinLimit = (gec_pkg::PIN_W + 1)'(PIN_COUNT);

    gec_pkg::t_reg_sel sel;
    logic              hi;
    logic              pin_ok;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign pin_ok  = {1'b0, i_pin_index} < PinLimit;

    always_comb begin
        hi  = 1'b0;
        sel = gec_pkg::REG_NONE;
        unique case (i_bus_offset)
            gec_pkg::OFS_OE_HI:   begin sel = gec_pkg::REG_OE;   hi = 1'b1; end
            gec_pkg::OFS_OUT_LO:  begin sel = gec_pkg::REG_OUT;  hi = 1'b0; end
            gec_pkg::OFS_OUT_HI:  begin sel = gec_pkg::REG_OUT;  hi = 1'b1; end
            gec_pkg::OFS_IN_LO:   begin sel = gec_pkg::REG_IN;   hi = 1'b0; end
            gec_pkg::OFS_IN_HI:   begin sel = gec_pkg::REG_IN;   hi = 1'b1; end
            gec_pkg::OFS_FALL_LO: begin sel = gec_pkg::REG_FALL; hi = 1'b0; end
            gec_pkg::OFS_FALL_HI: begin sel = gec_pkg::REG_FALL; hi = 1'b1; end
            gec_pkg::OFS_RISE_LO: begin sel = gec_pkg::REG_RISE; hi = 1'b0; end
            gec_pkg::OFS_RISE_HI: begin sel = gec_pkg::REG_RISE; hi = 1'b1; end
            gec_pkg::OFS_STAT_LO: begin sel = gec_pkg::REG_STAT; hi = 1'b0; end
            gec_pkg::OFS_STAT_HI: begin sel = gec_pkg::REG_STAT; hi = 1'b1; end
            default:              begin sel = gec_pkg::REG_NONE; hi = 1'b0; end
        endcase
    end

    always_comb begin
        o_cmd.sel   = sel;
        o_cmd.hi    = hi;
        o_cmd.data  = i_write_data;
        o_cmd.pin   = i_pin_index;
        o_cmd.level = i_pin_level;
        unique case (gec_pkg::t_action'(i_action))
            gec_pkg::ACT_READ:  o_cmd.kind = gec_pkg::K_READ;
            gec_pkg::ACT_WRITE: o_cmd.kind = gec_pkg::K_WRITE;
            // A pin beyond the fitted pins is dropped here and has no effect.
            gec_pkg::ACT_PIN:   o_cmd.kind = pin_ok ? gec_pkg::K_PIN : gec_pkg::K_NOP;
            default:            o_cmd.kind = gec_pkg::K_NOP;
        endcase
    end

endmodule

/* src/gec_queue.sv */
// Short command queue between the front and back parts, so that each side
// can stall on its own. Depends on gec_pkg.
module gec_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gec_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output gec_pkg::t_cmd o_cmd
);

    gec_pkg::t_cmd                  r_mem [gec_pkg::Q_DEPTH];
    logic [gec_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [gec_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [gec_pkg::Q_CNT_W-1:0]    r_count;
    logic [gec_pkg::Q_CNT_W-1:0]    n_count;

    localparam logic [gec_pkg::Q_CNT_W-1:0] Full = gec_pkg::Q_CNT_W'(gec_pkg::Q_DEPTH);
    localparam logic [gec_pkg::Q_PTR_W-1:0] Last = gec_pkg::Q_PTR_W'(gec_pkg::Q_DEPTH - 1);

    assign o_full  = (r_count == Full);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Last) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Last) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* src/gec_back.sv */
// Back part: holds the GPIO registers, carries out each queued command and
// registers the result beat. Depends on gec_pkg.
module gec_back #(
    parameter int PIN_COUNT = gec_pkg::PIN_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  gec_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gec_pkg::HALF_W-1:0]    o_read_data,
    output logic [gec_pkg::LEVEL_W-1:0]   o_brightness_level,
    output logic                          o_i2c_data_line,
    output logic                          o_i2c_clock_line,
    output logic                          o_irq_line
);

    localparam int PinW = $clog2(PIN_COUNT);
    localparam int HW   = gec_pkg::HALF_W;

    logic [gec_pkg::WORD_W-1:0] r_out,  n_out;
    logic [PIN_COUNT-1:0]       r_in,   n_in;
    logic [gec_pkg::WORD_W-1:0] r_fall, n_fall;
    logic [gec_pkg::WORD_W-1:0] r_rise, n_rise;
    logic [PIN_COUNT-1:0]       r_stat, n_stat;
    logic [2:0]                 r_oe,   n_oe;
    logic                       r_irq,  n_irq;

    logic                       r_ovalid;
    logic [HW-1:0]              r_rd;
    logic [gec_pkg::LEVEL_W-1:0] r_level;
    logic                       r_sda;
    logic                       r_scl;
    logic                       r_irq_out;

    logic                       ready;
    logic                       fire;
    logic [gec_pkg::WORD_W-1:0] in_view;
    logic [gec_pkg::WORD_W-1:0] stat_view;
    logic [HW-1:0]              rd;
    logic [PinW-1:0]            pidx;
    logic                       edge_en;

    assign ready = !r_ovalid || !i_stall;
    assign fire  = i_q_valid && ready;
    assign o_pop = fire;

    // Pins that are not fitted read as high in the input word and never
    // appear in the status word.
    assign in_view   = ~(gec_pkg::WORD_W'(~r_in));
    assign stat_view = gec_pkg::WORD_W'(r_stat);
    assign pidx      = i_cmd.pin[PinW-1:0];
    assign edge_en   = i_cmd.level ? r_rise[i_cmd.pin] : r_fall[i_cmd.pin];

    always_comb begin
        rd = '0;
        if (i_cmd.kind == gec_pkg::K_READ) begin
            unique case (i_cmd.sel)
                gec_pkg::REG_OE:   rd = HW'(r_oe);
                gec_pkg::REG_OUT:  rd = i_cmd.hi ? r_out[2*HW-1:HW]     : r_out[HW-1:0];
                gec_pkg::REG_IN:   rd = i_cmd.hi ? in_view[2*HW-1:HW]   : in_view[HW-1:0];
                gec_pkg::REG_FALL: rd = i_cmd.hi ? r_fall[2*HW-1:HW]    : r_fall[HW-1:0];
                gec_pkg::REG_RISE: rd = i_cmd.hi ? r_rise[2*HW-1:HW]    : r_rise[HW-1:0];
                gec_pkg::REG_STAT: rd = i_cmd.hi ? stat_view[2*HW-1:HW] : stat_view[HW-1:0];
                default:           rd = '0;
            endcase
        end
    end

    always_comb begin
        n_out  = r_out;
        n_in   = r_in;
        n_fall = r_fall;
        n_rise = r_rise;
        n_stat = r_stat;
        n_oe   = r_oe;
        n_irq  = r_irq;
        unique case (i_cmd.kind)
            gec_pkg::K_WRITE: begin
                unique case (i_cmd.sel)
                    gec_pkg::REG_OE: n_oe = i_cmd.data[2:0];
                    gec_pkg::REG_OUT: begin
                        if (i_cmd.hi) n_out[2*HW-1:HW] = i_cmd.data;
                        else          n_out[HW-1:0]    = i_cmd.data;
                    end
                    gec_pkg::REG_FALL: begin
                        if (i_cmd.hi) n_fall[2*HW-1:HW] = i_cmd.data;
                        else          n_fall[HW-1:0]    = i_cmd.data;
                    end
                    gec_pkg::REG_RISE: begin
                        if (i_cmd.hi) n_rise[2*HW-1:HW] = i_cmd.data;
                        else          n_rise[HW-1:0]    = i_cmd.data;
                    end
                    default: ;
                endcase
            end
            gec_pkg::K_PIN: begin
                n_in[pidx] = i_cmd.level;
                // Only a real level change that is enabled for its direction
                // replaces the status word and raises the interrupt.
                if (r_in[pidx] != i_cmd.level && edge_en) begin
                    n_stat       = '0;
                    n_stat[pidx] = 1'b1;
                    n_irq        = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out    <= '0;
            r_in     <= '1;
            r_fall   <= '0;
            r_rise   <= '0;
            r_stat   <= '0;
            r_oe     <= '0;
            r_irq    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (ready) begin
                r_ovalid <= i_q_valid;
            end
            if (fire) begin
                r_out  <= n_out;
                r_in   <= n_in;
                r_fall <= n_fall;
                r_rise <= n_rise;
                r_stat <= n_stat;
                r_oe   <= n_oe;
                r_irq  <= n_irq;
            end
        end
    end

    // The result beat shows the register state after the command.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rd      <= rd;
            r_level   <= gec_pkg::decode_brightness({n_out[18:16], n_oe});
            r_sda     <= n_out[29];
            r_scl     <= n_out[30];
            r_irq_out <= n_irq;
        end
    end

    assign o_valid            = r_ovalid;
    assign o_read_data        = r_rd;
    assign o_brightness_level = r_level;
    assign o_i2c_data_line    = r_sda;
    assign o_i2c_clock_line   = r_scl;
    assign o_irq_line         = r_irq_out;

endmodule

/* src/gpio_edge_interrupt_controller.sv */
// GPIO edge interrupt controller, top level: wires the front decoder, the
// command queue and the back part together. Depends on gec_pkg and the gec_ modules.
//
// Use: each input beat on i_valid/o_stall is a bus read, a bus write of a
// 16-bit register half, or a pin level event. Every input beat gives exactly
// one result beat on o_valid/i_stall, in order: the read data (zero for
// anything but a read of a known offset), the decoded brightness level, the
// two I2C lines taken from output bits 29 and 30, and the sticky interrupt.
// An accepted beat goes through the command queue and the back part's output
// register to o_valid; one beat is taken every cycle while o_stall is low.
// A two-entry command queue sits between decode and execution, and the
// result is held in an output register, so a new beat is still taken while
// a result waits. When i_stall holds the result, the queue fills and o_stall
// rises once the queue holds two commands.
// Reset (synchronous, active low) clears the output, enable and status words
// and the interrupt, sets the input word to all ones and empties the queue.
module gpio_edge_interrupt_controller #(
    parameter int PIN_COUNT = gec_pkg::PIN_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_action,
    input  logic [gec_pkg::OFS_W-1:0]     i_bus_offset,
    input  logic [gec_pkg::HALF_W-1:0]    i_write_data,
    input  logic [gec_pkg::PIN_W-1:0]     i_pin_index,
    input  logic                          i_pin_level,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gec_pkg::HALF_W-1:0]    o_read_data,
    output logic [gec_pkg::LEVEL_W-1:0]   o_brightness_level,
    output logic                          o_i2c_data_line,
    output logic                          o_i2c_clock_line,
    output logic                          o_irq_line
);

    logic          q_full;
    logic          push;
    logic          pop;
    logic          q_valid;
    gec_pkg::t_cmd front_cmd;
    gec_pkg::t_cmd back_cmd;

    gec_front #(
        .PIN_COUNT (PIN_COUNT)
    ) u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_bus_offset (i_bus_offset),
        .i_write_data (i_write_data),
        .i_pin_index  (i_pin_index),
        .i_pin_level  (i_pin_level),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    gec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (back_cmd)
    );

    gec_back #(
        .PIN_COUNT (PIN_COUNT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_cmd              (back_cmd),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_read_data        (o_read_data),
        .o_brightness_level (o_brightness_level),
        .o_i2c_data_line    (o_i2c_data_line),
        .o_i2c_clock_line   (o_i2c_clock_line),
        .o_irq_line         (o_irq_line)
    );

endmodule
